// ----- design/ilm_pkg.sv -----
// ----------------------------------------------------------------------------
// ilm_pkg
// Shared types, constants and the divide-by-125 digit step for the interrupt
// latency monitor.
// ----------------------------------------------------------------------------
package ilm_pkg;

  typedef enum logic [1:0] {
    CMD_START     = 2'd0,
    CMD_COMPLETE  = 2'd1,
    CMD_READ_ALL  = 2'd2,
    CMD_READ_SLOW = 2'd3
  } cmd_t;

  localparam logic REG_LOG_LEVEL      = 1'b0;
  localparam logic REG_SLOW_THRESHOLD = 1'b1;

  localparam int IDX_W      = 10;
  localparam int WIN_BITS   = 6;
  localparam int WIN_DEPTH  = 1 << WIN_BITS;
  localparam int SUM_W      = 32 + WIN_BITS;
  localparam int ALL_BITS   = 10;
  localparam int ALL_DEPTH  = 1 << ALL_BITS;
  localparam int SLOW_BITS  = 8;
  localparam int SLOW_DEPTH = 1 << SLOW_BITS;

  localparam logic [7:0]  LOG_ON_LEVEL = 8'd2;
  localparam logic [31:0] SLOW_RESET   = 32'd2000;

  // 1000 * 2^32: first elapsed time whose microsecond count overflows 32 bits
  localparam logic [63:0] SAT_LIMIT    = 64'd4294967296000;

  // digit step: {rem, 10-bit chunk} / 125 by reciprocal multiply
  localparam logic [17:0] RECIP_125    = 18'd134218;
  localparam int          RECIP_SHIFT  = 24;
  localparam logic [6:0]  DIV_125      = 7'd125;

  typedef struct packed {
    cmd_t             cmd;
    logic [63:0]      ts;
    logic [IDX_W-1:0] idx;
  } item_t;

  typedef struct packed {
    item_t       item;
    logic [31:0] lat;
  } lat_item_t;

  typedef struct packed {
    logic                 complete;
    logic [31:0]          lat;
    logic [63:0]          ts;
    logic                 dbg_on;
    logic                 slow_hit;
    logic [SLOW_BITS-1:0] slow_addr;
  } log_cmd_t;

  typedef struct packed {
    logic        all_en;
    logic        slow_en;
    logic        slow_write;
    logic        all_valid;
    logic [31:0] all_data;
    logic        slow_valid;
    logic [63:0] slow_data;
  } log_stat_t;

  // returns {quotient digit, remainder}
  function automatic logic [16:0] div125_step(input logic [6:0] rem, input logic [9:0] chunk);
    logic [16:0] t;
    logic [34:0] prod;
    logic [9:0]  qd;
    logic [16:0] back;
    t    = {rem, chunk};
    prod = 35'(t) * 35'(RECIP_125);
    qd   = prod[RECIP_SHIFT +: 10];
    back = 17'(qd) * 17'(DIV_125);
    return {qd, 7'(t - back)};
  endfunction

endpackage

// ----- design/ilm_latency.sv -----
// ----------------------------------------------------------------------------
// ilm_latency
// Input register, elapsed time against the start mark, and a two-stage
// divide by 1000 with saturation to 32 bits.
// ----------------------------------------------------------------------------
module ilm_latency
  import ilm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  item_t     in_item,
  output logic      lat_valid,
  output lat_item_t lat_item,
  input  logic      lat_ready
);

  typedef struct packed {
    item_t       item;
    logic [63:0] diff;
  } s1_t;

  typedef struct packed {
    item_t       item;
    logic        sat;
    logic [11:0] q_hi;
    logic [6:0]  rem;
    logic [19:0] x_lo;
  } s2_t;

  logic        v0, v1, v2;
  logic        rdy0, rdy1, rdy2;
  item_t       s0;
  s1_t         s1;
  s2_t         s2;
  logic [63:0] start_time;

  logic [39:0] x40;
  logic [16:0] step3, step2, step1, step0;
  logic        sat;
  logic [31:0] lat;

  assign rdy2     = !v2 || lat_ready;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_stall = !rdy0;

  // (diff >> 3) / 125, top two digits
  always_comb begin
    x40   = {1'b0, s1.diff[41:3]};
    step3 = div125_step(7'd0, x40[39:30]);
    step2 = div125_step(step3[6:0], x40[29:20]);
    sat   = s1.diff >= SAT_LIMIT;
  end

  // low two digits
  always_comb begin
    step1 = div125_step(s2.rem, s2.x_lo[19:10]);
    step0 = div125_step(step1[6:0], s2.x_lo[9:0]);
    lat   = s2.sat ? '1 : {s2.q_hi, step1[16:7], step0[16:7]};
  end

  assign lat_valid     = v2;
  assign lat_item.item = s2.item;
  assign lat_item.lat  = lat;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0         <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      start_time <= '0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (v0 && rdy1 && s0.cmd == CMD_START) start_time <= s0.ts;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) s0 <= in_item;
    if (rdy1) begin
      s1.item <= s0;
      s1.diff <= s0.ts - start_time;
    end
    if (rdy2) begin
      s2.item <= s1.item;
      s2.sat  <= sat;
      s2.q_hi <= {step3[8:7], step2[16:7]};
      s2.rem  <= step2[6:0];
      s2.x_lo <= x40[19:0];
    end
  end

endmodule

// ----- design/ilm_window.sv -----
// ----------------------------------------------------------------------------
// ilm_window
// Sliding window of latencies with running sum and latched average.
// ----------------------------------------------------------------------------
module ilm_window
  import ilm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                commit,
  input  logic [WIN_BITS-1:0] slot,
  input  logic [WIN_BITS-1:0] slot_rd,
  input  logic [31:0]         lat,
  output logic [31:0]         avg_next
);

  logic [31:0]      win_mem [WIN_DEPTH];
  logic [31:0]      rd_data;
  logic             full;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [31:0]      avg_latched;
  logic [31:0]      old;

  // entries read as zero until the window has wrapped once
  assign old      = full ? rd_data : '0;
  assign sum_next = commit ? sum - SUM_W'(old) + SUM_W'(lat) : sum;
  assign avg_next = (commit && slot == '0) ? sum_next[SUM_W-1:WIN_BITS] : avg_latched;

  always_ff @(posedge clk) begin
    if (rst) begin
      full        <= 1'b0;
      sum         <= '0;
      avg_latched <= '0;
    end else begin
      sum         <= sum_next;
      avg_latched <= avg_next;
      if (commit && slot == WIN_BITS'(WIN_DEPTH - 1)) full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) win_mem[slot] <= lat;
    rd_data <= win_mem[slot_rd];
  end

endmodule

// ----- design/ilm_logs.sv -----
// ----------------------------------------------------------------------------
// ilm_logs
// Sticky latency log and slow-event time log with fill tracking and
// write-to-read forwarding.
// ----------------------------------------------------------------------------
module ilm_logs
  import ilm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [IDX_W-1:0] rd_idx,
  input  log_cmd_t         lc,
  output log_stat_t        stat
);

  logic [31:0]          all_mem  [ALL_DEPTH];
  logic [63:0]          slow_mem [SLOW_DEPTH];
  logic                 all_en, slow_en;
  logic                 all_en_next, slow_en_next;
  logic                 all_we, slow_we;
  logic [ALL_BITS-1:0]  all_ptr;
  logic                 all_full;
  logic [SLOW_BITS:0]   slow_fill;
  logic [ALL_BITS-1:0]  all_idx;
  logic [SLOW_BITS-1:0] slow_idx;
  logic                 all_hit, slow_hit;
  logic                 all_valid, slow_valid;
  logic [31:0]          all_data;
  logic [63:0]          slow_data;

  assign all_en_next  = all_en || (lc.complete && lc.dbg_on);
  assign all_we       = lc.complete && all_en_next;
  assign slow_en_next = slow_en || (lc.complete && lc.slow_hit && lc.dbg_on);
  assign slow_we      = lc.complete && lc.slow_hit && slow_en_next;

  assign all_idx  = rd_idx[ALL_BITS-1:0];
  assign slow_idx = rd_idx[SLOW_BITS-1:0];
  assign all_hit  = all_we && all_ptr == all_idx;
  assign slow_hit = slow_we && lc.slow_addr == slow_idx;

  assign stat.all_en     = all_en;
  assign stat.slow_en    = slow_en;
  assign stat.slow_write = slow_we;
  assign stat.all_valid  = all_valid;
  assign stat.all_data   = all_data;
  assign stat.slow_valid = slow_valid;
  assign stat.slow_data  = slow_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      all_en    <= 1'b0;
      slow_en   <= 1'b0;
      all_ptr   <= '0;
      all_full  <= 1'b0;
      slow_fill <= '0;
    end else begin
      all_en  <= all_en_next;
      slow_en <= slow_en_next;
      if (all_we) begin
        all_ptr <= all_ptr + 1'b1;
        if (all_ptr == '1) all_full <= 1'b1;
      end
      // slow writes restart at zero, so entries below the fill mark stay written
      if (slow_we && !slow_fill[SLOW_BITS] && lc.slow_addr == slow_fill[SLOW_BITS-1:0]) begin
        slow_fill <= slow_fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (all_we) all_mem[all_ptr] <= lc.lat;
    if (slow_we) slow_mem[lc.slow_addr] <= lc.ts;
    if (load) begin
      all_data   <= all_hit ? lc.lat : all_mem[all_idx];
      all_valid  <= all_hit || all_full || all_idx < all_ptr;
      slow_data  <= slow_hit ? lc.ts : slow_mem[slow_idx];
      slow_valid <= slow_hit || slow_fill[SLOW_BITS] ||
                    slow_idx < slow_fill[SLOW_BITS-1:0];
    end
  end

endmodule

// ----- design/interrupt_latency_monitor.sv -----
// ----------------------------------------------------------------------------
// interrupt_latency_monitor
// Throughput: one request per cycle while out_stall is low, through the
// pipeline stages (time difference, two divide-by-1000 digit stages, state
// commit).
// Reset (synchronous): clears counters, flags, pointers and fill marks;
// log and window memories are not swept, unwritten entries read as zero.
// ----------------------------------------------------------------------------
module interrupt_latency_monitor
  import ilm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [63:0] timestamp_ns,
  input  logic [9:0]  log_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] avg_latency_us,
  output logic [31:0] high_latency_us,
  output logic [31:0] slow_count,
  output logic [31:0] event_count,
  output logic [63:0] log_value,
  output logic        log_present,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [7:0]  log_level;
  logic [31:0] slow_threshold_us;

  item_t       in_item;
  logic        lat_valid;
  lat_item_t   lat_item;

  logic        v3;
  lat_item_t   s3;
  logic        ready_out, rdy3, commit, complete, load;

  logic [31:0] completions, completions_next;
  logic [31:0] slow_events, slow_events_next, se_base;
  logic [31:0] peak, peak_next;
  logic [31:0] avg_next;
  logic [63:0] value;
  logic        present;

  log_cmd_t    lc;
  log_stat_t   stat;

  assign in_item.cmd = cmd_t'(cmd);
  assign in_item.ts  = timestamp_ns;
  assign in_item.idx = log_index;

  ilm_latency u_latency (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .lat_valid (lat_valid),
    .lat_item  (lat_item),
    .lat_ready (rdy3)
  );

  assign ready_out = !out_valid || !out_stall;
  assign rdy3      = !v3 || ready_out;
  assign commit    = v3 && ready_out;
  assign complete  = commit && s3.item.cmd == CMD_COMPLETE;
  assign load      = lat_valid && rdy3;

  // slow count restarts whenever a completion finds the event count at zero
  assign se_base          = (completions == '0) ? '0 : slow_events;
  assign completions_next = complete ? completions + 32'd1 : completions;
  assign slow_events_next = complete ? se_base + 32'(stat.slow_write) : slow_events;
  assign peak_next        = (complete && s3.lat > peak) ? s3.lat : peak;

  assign lc.complete  = complete;
  assign lc.lat       = s3.lat;
  assign lc.ts        = s3.item.ts;
  assign lc.dbg_on    = log_level >= LOG_ON_LEVEL;
  assign lc.slow_hit  = s3.lat > slow_threshold_us;
  assign lc.slow_addr = se_base[SLOW_BITS-1:0];

  ilm_logs u_logs (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .rd_idx (lat_item.item.idx),
    .lc     (lc),
    .stat   (stat)
  );

  ilm_window u_window (
    .clk      (clk),
    .rst      (rst),
    .commit   (complete),
    .slot     (completions[WIN_BITS-1:0]),
    .slot_rd  (completions_next[WIN_BITS-1:0]),
    .lat      (s3.lat),
    .avg_next (avg_next)
  );

  always_comb begin
    value   = '0;
    present = 1'b0;
    case (s3.item.cmd)
      CMD_READ_ALL: begin
        value   = stat.all_valid ? 64'(stat.all_data) : '0;
        present = stat.all_en;
      end
      CMD_READ_SLOW: begin
        value   = stat.slow_valid ? stat.slow_data : '0;
        present = stat.slow_en;
      end
      default: begin
        value   = '0;
        present = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      log_level         <= '0;
      slow_threshold_us <= SLOW_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOG_LEVEL:      log_level         <= cfg_data[7:0];
        REG_SLOW_THRESHOLD: slow_threshold_us <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3          <= 1'b0;
      out_valid   <= 1'b0;
      completions <= '0;
      slow_events <= '0;
      peak        <= '0;
    end else begin
      if (rdy3) v3 <= lat_valid;
      if (ready_out) out_valid <= v3;
      completions <= completions_next;
      slow_events <= slow_events_next;
      peak        <= peak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) s3 <= lat_item;
    if (commit) begin
      avg_latency_us  <= avg_next;
      high_latency_us <= peak_next;
      slow_count      <= slow_events_next;
      event_count     <= completions_next;
      log_value       <= value;
      log_present     <= present;
    end
  end

endmodule

// ----- design/ilm_checker.sv -----
// ----------------------------------------------------------------------------
// ilm_checker
// Port-level checks for the interrupt latency monitor, bound to the top level.
// ----------------------------------------------------------------------------
module ilm_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] high_latency_us,
  input logic [31:0] event_count,
  input logic [63:0] log_value
);

  logic        out_take;
  logic        have_last;
  logic [31:0] last_high;
  logic [31:0] last_count;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
    end else if (out_take) begin
      have_last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      last_high  <= high_latency_us;
      last_count <= event_count;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_peak_rising: assert property (@(posedge clk) disable iff (rst)
    out_take && have_last |-> high_latency_us >= last_high)
    else $error("highest latency went down");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_take && have_last |->
      (event_count == last_count) || (event_count == last_count + 32'd1))
    else $error("event count jumped between results");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_count) && $stable(log_value))
    else $error("stalled result changed");

endmodule

bind interrupt_latency_monitor ilm_port_checks u_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .high_latency_us (high_latency_us),
  .event_count     (event_count),
  .log_value       (log_value)
);
